// ===== rtl/m1cf_pkg.sv =====
// constants shared by the m1 closure flux datapath
// no dependencies; imported by the top level
`timescale 1ns / 1ps

package m1cf_pkg;

    localparam int PSI_W  = 31;   // energy density, unsigned q7.24
    localparam int FLUX_W = 32;   // flux components, signed q8.24
    localparam int OUT_W  = 32;   // result fields
    localparam int SQ_W   = 64;   // squares and their sum, q16.48
    localparam int ROOT_W = 32;   // square root results
    localparam int Q_W    = 31;   // q1.30 values that may reach one
    localparam int N_W    = 33;   // numerator of the divide by three

    localparam logic [Q_W-1:0] ONE30   = Q_W'(1) << 30;
    localparam logic [Q_W-1:0] HALF30  = Q_W'(1) << 29;
    localparam logic [N_W-1:0] FOUR30  = N_W'(4) << 30;
    localparam logic [N_W-1:0] FIVE30P = (N_W'(5) << 30) + N_W'(1);

    // floor(2^34 / 3), used with a one step correction
    localparam logic [N_W-1:0] RECIP3       = 33'd5726623061;
    localparam int             RECIP3_SHIFT = 34;

endpackage

// ===== rtl/m1cf_isqrt.sv =====
// pipelined integer square root, one result bit per stage
// no dependencies; instantiated by the top level
`timescale 1ns / 1ps

module m1cf_isqrt #(
    parameter int W    = 64,
    parameter int SB_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [W-1:0]      in_val,
    input  logic [SB_W-1:0]   in_sb,
    output logic              out_valid,
    output logic [W/2-1:0]    out_root,
    output logic [SB_W-1:0]   out_sb
);

    localparam int STAGES = W / 2;

    logic [W-1:0]    v_reg    [STAGES];
    logic [W-1:0]    r_reg    [STAGES];
    logic [SB_W-1:0] sb_reg   [STAGES];
    logic [STAGES-1:0] vld_reg;

    logic [W-1:0] v_cur  [STAGES];
    logic [W-1:0] r_cur  [STAGES];
    logic [W-1:0] v_next [STAGES];
    logic [W-1:0] r_next [STAGES];

    always_comb begin
        logic [W:0]   sum;
        logic [W-1:0] bitv;
        v_cur[0] = in_val;
        r_cur[0] = '0;
        for (int k = 1; k < STAGES; k++) begin
            v_cur[k] = v_reg[k-1];
            r_cur[k] = r_reg[k-1];
        end
        for (int k = 0; k < STAGES; k++) begin
            bitv = {{(W-1){1'b0}}, 1'b1} << (W - 2 - 2 * k);
            sum  = {1'b0, r_cur[k]} + {1'b0, bitv};
            if ({1'b0, v_cur[k]} >= sum) begin
                v_next[k] = v_cur[k] - sum[W-1:0];
                r_next[k] = (r_cur[k] >> 1) + bitv;
            end else begin
                v_next[k] = v_cur[k];
                r_next[k] = r_cur[k] >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sb_reg[0] <= in_sb;
            for (int k = 1; k < STAGES; k++) begin
                sb_reg[k] <= sb_reg[k-1];
            end
            for (int k = 0; k < STAGES; k++) begin
                v_reg[k] <= v_next[k];
                r_reg[k] <= r_next[k];
            end
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign out_root  = r_reg[STAGES-1][W/2-1:0];
    assign out_sb    = sb_reg[STAGES-1];

endmodule

// ===== rtl/m1cf_ratio.sv =====
// pipelined restoring divider, floor(num * 2^(QB-1) / den) for num <= den
// no dependencies; instantiated by the top level
`timescale 1ns / 1ps

module m1cf_ratio #(
    parameter int W    = 64,
    parameter int QB   = 31,
    parameter int SB_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [W-1:0]      in_num,
    input  logic [W-1:0]      in_den,
    input  logic [SB_W-1:0]   in_sb,
    output logic              out_valid,
    output logic [QB-1:0]     out_q,
    output logic [SB_W-1:0]   out_sb
);

    logic [W-1:0]    rem_reg [QB];
    logic [W-1:0]    den_reg [QB];
    logic [QB-1:0]   q_reg   [QB];
    logic [SB_W-1:0] sb_reg  [QB];
    logic [QB-1:0]   vld_reg;

    logic [W-1:0]  rem_cur  [QB];
    logic [W-1:0]  den_cur  [QB];
    logic [QB-1:0] q_cur    [QB];
    logic [W-1:0]  rem_next [QB];
    logic [QB-1:0] q_next   [QB];

    always_comb begin
        logic [W:0] shifted;
        logic [W:0] diff;
        logic       ge;
        rem_cur[0] = in_num;
        den_cur[0] = in_den;
        q_cur[0]   = '0;
        for (int k = 1; k < QB; k++) begin
            rem_cur[k] = rem_reg[k-1];
            den_cur[k] = den_reg[k-1];
            q_cur[k]   = q_reg[k-1];
        end
        for (int k = 0; k < QB; k++) begin
            // integer bit first, then one fraction bit per stage
            if (k == 0) begin
                shifted = {1'b0, rem_cur[k]};
            end else begin
                shifted = {rem_cur[k], 1'b0};
            end
            diff        = shifted - {1'b0, den_cur[k]};
            ge          = shifted >= {1'b0, den_cur[k]};
            rem_next[k] = ge ? diff[W-1:0] : shifted[W-1:0];
            q_next[k]   = {q_cur[k][QB-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[QB-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sb_reg[0] <= in_sb;
            for (int k = 1; k < QB; k++) begin
                sb_reg[k] <= sb_reg[k-1];
            end
            for (int k = 0; k < QB; k++) begin
                rem_reg[k] <= rem_next[k];
                den_reg[k] <= den_cur[k];
                q_reg[k]   <= q_next[k];
            end
        end
    end

    assign out_valid = vld_reg[QB-1];
    assign out_q     = q_reg[QB-1];
    assign out_sb    = sb_reg[QB-1];

endmodule

// ===== rtl/m1_closure_flux_2d.sv =====
// m1 closure flux for one 2d node: pressure tensor from energy density and flux
// depends on m1cf_pkg, m1cf_isqrt and m1cf_ratio
`timescale 1ns / 1ps

// usage
//   input channel s_*: energy density psi0 (unsigned q7.24) and flux x/y
//   (signed q8.24), one transfer per node
//   result channel m_*: the flux passed through plus the symmetric pressure
//   tensor entries xx, xy, yy, saturated to 32 bit signed q8.24
//   throughput: one node per cycle while results are taken; the pipeline
//   is a single chain of 108 register stages, set by two 32 stage square
//   root units and the 31 stage divider bank (flux factor and three tensor
//   ratios side by side)
//   stall: when the output register holds an untaken result the whole
//   pipeline freezes and s_ready drops; bubbles ahead of the output still
//   move up while the output register is empty
//   reset: aresetn (synchronous, active low) clears all valid bits; no
//   result is in flight afterwards, payload registers are not cleared
//   there is no configuration and no state carried between nodes

module m1_closure_flux_2d
    import m1cf_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [PSI_W-1:0]         s_energy_density,
    input  logic signed [FLUX_W-1:0] s_flux_x,
    input  logic signed [FLUX_W-1:0] s_flux_y,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [OUT_W-1:0]  m_energy_flux_x,
    output logic signed [OUT_W-1:0]  m_energy_flux_y,
    output logic signed [OUT_W-1:0]  m_pressure_xx,
    output logic signed [OUT_W-1:0]  m_pressure_xy,
    output logic signed [OUT_W-1:0]  m_pressure_yy
);

    localparam int SB1_W = PSI_W + 2 * FLUX_W + 4 * SQ_W;
    localparam int SB2_W = PSI_W + 2 * FLUX_W + 3 * Q_W + 1;

    // round half up then shift by 31, saturate to signed 32 bit
    function automatic logic [OUT_W-1:0] scale_sat(input logic [SQ_W-1:0] prod,
                                                   input logic            neg);
        logic [SQ_W-1:0] rnd;
        logic [32:0]     m;
        logic [32:0]     lim;
        rnd = prod + (SQ_W'(1) << 30);
        m   = rnd[63:31];
        if (!neg) begin
            lim = 33'h0_7FFF_FFFF;
            scale_sat = (m > lim) ? lim[OUT_W-1:0] : m[OUT_W-1:0];
        end else begin
            lim = 33'h1_0000_0000 >> 1;
            if (m > lim) begin
                m = lim;
            end
            scale_sat = OUT_W'(33'd0 - m);
        end
    endfunction

    logic adv;
    logic out_vld_reg;

    // whole pipeline moves unless a finished result is waiting
    assign adv     = m_ready || !out_vld_reg;
    assign s_ready = adv;
    assign m_valid = out_vld_reg;

    // stage 1: capture, magnitudes
    logic               p1_vld_reg;
    logic [PSI_W-1:0]   p1_psi0_reg;
    logic [FLUX_W-1:0]  p1_fx_reg, p1_fy_reg, p1_magx_reg, p1_magy_reg;
    logic [FLUX_W-1:0]  magx_next, magy_next;

    assign magx_next = s_flux_x[FLUX_W-1] ? (FLUX_W'(0) - $unsigned(s_flux_x))
                                          : $unsigned(s_flux_x);
    assign magy_next = s_flux_y[FLUX_W-1] ? (FLUX_W'(0) - $unsigned(s_flux_y))
                                          : $unsigned(s_flux_y);

    // stage 2: squares and cross product
    logic              p2_vld_reg;
    logic [PSI_W-1:0]  p2_psi0_reg;
    logic [FLUX_W-1:0] p2_fx_reg, p2_fy_reg;
    logic [SQ_W-1:0]   p2_sqx_reg, p2_sqy_reg, p2_pxy_reg;

    // stage 3: squared norm
    logic              p3_vld_reg;
    logic [PSI_W-1:0]  p3_psi0_reg;
    logic [FLUX_W-1:0] p3_fx_reg, p3_fy_reg;
    logic [SQ_W-1:0]   p3_sqx_reg, p3_sqy_reg, p3_pxy_reg, p3_s_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            p3_vld_reg <= 1'b0;
        end else if (adv) begin
            p1_vld_reg <= s_valid;
            p2_vld_reg <= p1_vld_reg;
            p3_vld_reg <= p2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_psi0_reg <= s_energy_density;
            p1_fx_reg   <= s_flux_x;
            p1_fy_reg   <= s_flux_y;
            p1_magx_reg <= magx_next;
            p1_magy_reg <= magy_next;

            p2_psi0_reg <= p1_psi0_reg;
            p2_fx_reg   <= p1_fx_reg;
            p2_fy_reg   <= p1_fy_reg;
            p2_sqx_reg  <= SQ_W'(p1_magx_reg) * SQ_W'(p1_magx_reg);
            p2_sqy_reg  <= SQ_W'(p1_magy_reg) * SQ_W'(p1_magy_reg);
            p2_pxy_reg  <= SQ_W'(p1_magx_reg) * SQ_W'(p1_magy_reg);

            p3_psi0_reg <= p2_psi0_reg;
            p3_fx_reg   <= p2_fx_reg;
            p3_fy_reg   <= p2_fy_reg;
            p3_sqx_reg  <= p2_sqx_reg;
            p3_sqy_reg  <= p2_sqy_reg;
            p3_pxy_reg  <= p2_pxy_reg;
            p3_s_reg    <= p2_sqx_reg + p2_sqy_reg;
        end
    end

    // |psi1| = floor(sqrt(S))
    logic              sq1_vld;
    logic [ROOT_W-1:0] sq1_root;
    logic [SB1_W-1:0]  sq1_sb;

    m1cf_isqrt #(
        .W    (SQ_W),
        .SB_W (SB1_W)
    ) u_norm_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (p3_vld_reg),
        .in_val    (p3_s_reg),
        .in_sb     ({p3_psi0_reg, p3_fx_reg, p3_fy_reg,
                     p3_sqx_reg, p3_sqy_reg, p3_pxy_reg, p3_s_reg}),
        .out_valid (sq1_vld),
        .out_root  (sq1_root),
        .out_sb    (sq1_sb)
    );

    logic [PSI_W-1:0]  q1_psi0;
    logic [FLUX_W-1:0] q1_fx, q1_fy;
    logic [SQ_W-1:0]   q1_sqx, q1_sqy, q1_pxy, q1_s;
    logic [ROOT_W-1:0] den_f_next, num_f_next;
    logic [SQ_W-1:0]   den_s_next;

    assign {q1_psi0, q1_fx, q1_fy, q1_sqx, q1_sqy, q1_pxy, q1_s} = sq1_sb;

    // floor the divisors at one lsb; clamping num to den gives f = 1 exactly
    assign den_f_next = (q1_psi0 == '0) ? ROOT_W'(1) : ROOT_W'(q1_psi0);
    assign num_f_next = (sq1_root >= den_f_next) ? den_f_next : sq1_root;
    assign den_s_next = (q1_s == '0) ? SQ_W'(1) : q1_s;

    // stage 4: divider operands
    logic              p4_vld_reg;
    logic [PSI_W-1:0]  p4_psi0_reg;
    logic [FLUX_W-1:0] p4_fx_reg, p4_fy_reg;
    logic [ROOT_W-1:0] p4_numf_reg, p4_denf_reg;
    logic [SQ_W-1:0]   p4_sqx_reg, p4_sqy_reg, p4_pxy_reg, p4_dens_reg;
    logic              p4_negxy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p4_vld_reg <= 1'b0;
        end else if (adv) begin
            p4_vld_reg <= sq1_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p4_psi0_reg  <= q1_psi0;
            p4_fx_reg    <= q1_fx;
            p4_fy_reg    <= q1_fy;
            p4_numf_reg  <= num_f_next;
            p4_denf_reg  <= den_f_next;
            p4_sqx_reg   <= q1_sqx;
            p4_sqy_reg   <= q1_sqy;
            p4_pxy_reg   <= q1_pxy;
            p4_dens_reg  <= den_s_next;
            p4_negxy_reg <= q1_fx[FLUX_W-1] ^ q1_fy[FLUX_W-1];
        end
    end

    // divider bank: flux factor and the three direction ratios in lockstep
    logic              dv_vld;
    logic [Q_W-1:0]    dv_f, dv_rxx, dv_rxy, dv_ryy;
    logic              dv_negxy;
    logic [FLUX_W-1:0] dv_fx, dv_fy;
    logic [PSI_W-1:0]  dv_psi0;

    m1cf_ratio #(
        .W    (ROOT_W),
        .QB   (Q_W),
        .SB_W (1)
    ) u_div_f (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (p4_vld_reg),
        .in_num    (p4_numf_reg),
        .in_den    (p4_denf_reg),
        .in_sb     (p4_negxy_reg),
        .out_valid (dv_vld),
        .out_q     (dv_f),
        .out_sb    (dv_negxy)
    );

    m1cf_ratio #(
        .W    (SQ_W),
        .QB   (Q_W),
        .SB_W (FLUX_W)
    ) u_div_xx (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (p4_vld_reg),
        .in_num    (p4_sqx_reg),
        .in_den    (p4_dens_reg),
        .in_sb     (p4_fx_reg),
        .out_valid (),
        .out_q     (dv_rxx),
        .out_sb    (dv_fx)
    );

    m1cf_ratio #(
        .W    (SQ_W),
        .QB   (Q_W),
        .SB_W (PSI_W)
    ) u_div_xy (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (p4_vld_reg),
        .in_num    (p4_pxy_reg),
        .in_den    (p4_dens_reg),
        .in_sb     (p4_psi0_reg),
        .out_valid (),
        .out_q     (dv_rxy),
        .out_sb    (dv_psi0)
    );

    m1cf_ratio #(
        .W    (SQ_W),
        .QB   (Q_W),
        .SB_W (FLUX_W)
    ) u_div_yy (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (p4_vld_reg),
        .in_num    (p4_sqy_reg),
        .in_den    (p4_dens_reg),
        .in_sb     (p4_fy_reg),
        .out_valid (),
        .out_q     (dv_ryy),
        .out_sb    (dv_fy)
    );

    // stage 5: f squared
    logic              p5_vld_reg;
    logic [2*Q_W-1:0]  p5_ff_reg;
    logic [Q_W-1:0]    p5_rxx_reg, p5_rxy_reg, p5_ryy_reg;
    logic [PSI_W-1:0]  p5_psi0_reg;
    logic [FLUX_W-1:0] p5_fx_reg, p5_fy_reg;
    logic              p5_negxy_reg;

    // stage 6: radicand 4 - 3 f^2, moved to q.60
    logic              p6_vld_reg;
    logic [SQ_W-1:0]   p6_tin_reg;
    logic [Q_W-1:0]    p6_rxx_reg, p6_rxy_reg, p6_ryy_reg;
    logic [PSI_W-1:0]  p6_psi0_reg;
    logic [FLUX_W-1:0] p6_fx_reg, p6_fy_reg;
    logic              p6_negxy_reg;

    logic [2*Q_W-1:0]  f2_rnd;
    logic [Q_W-1:0]    f2_next;
    logic [N_W-1:0]    three_f2;
    logic [N_W-1:0]    t_next;

    assign f2_rnd   = p5_ff_reg + (2*Q_W)'(HALF30);
    assign f2_next  = f2_rnd[60:30];
    assign three_f2 = N_W'(f2_next) + (N_W'(f2_next) << 1);
    assign t_next   = (FOUR30 > three_f2) ? (FOUR30 - three_f2) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p5_vld_reg <= 1'b0;
            p6_vld_reg <= 1'b0;
        end else if (adv) begin
            p5_vld_reg <= dv_vld;
            p6_vld_reg <= p5_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p5_ff_reg    <= (2*Q_W)'(dv_f) * (2*Q_W)'(dv_f);
            p5_rxx_reg   <= dv_rxx;
            p5_rxy_reg   <= dv_rxy;
            p5_ryy_reg   <= dv_ryy;
            p5_psi0_reg  <= dv_psi0;
            p5_fx_reg    <= dv_fx;
            p5_fy_reg    <= dv_fy;
            p5_negxy_reg <= dv_negxy;

            p6_tin_reg   <= {1'b0, t_next, 30'd0};
            p6_rxx_reg   <= p5_rxx_reg;
            p6_rxy_reg   <= p5_rxy_reg;
            p6_ryy_reg   <= p5_ryy_reg;
            p6_psi0_reg  <= p5_psi0_reg;
            p6_fx_reg    <= p5_fx_reg;
            p6_fy_reg    <= p5_fy_reg;
            p6_negxy_reg <= p5_negxy_reg;
        end
    end

    // s = sqrt(4 - 3 f^2) in q2.30
    logic              sq2_vld;
    logic [ROOT_W-1:0] sq2_root;
    logic [SB2_W-1:0]  sq2_sb;

    m1cf_isqrt #(
        .W    (SQ_W),
        .SB_W (SB2_W)
    ) u_chi_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (p6_vld_reg),
        .in_val    (p6_tin_reg),
        .in_sb     ({p6_psi0_reg, p6_fx_reg, p6_fy_reg,
                     p6_rxx_reg, p6_rxy_reg, p6_ryy_reg, p6_negxy_reg}),
        .out_valid (sq2_vld),
        .out_root  (sq2_root),
        .out_sb    (sq2_sb)
    );

    logic [PSI_W-1:0]  q2_psi0;
    logic [FLUX_W-1:0] q2_fx, q2_fy;
    logic [Q_W-1:0]    q2_rxx, q2_rxy, q2_ryy;
    logic              q2_negxy;
    logic [N_W-1:0]    n_next;

    assign {q2_psi0, q2_fx, q2_fy, q2_rxx, q2_rxy, q2_ryy, q2_negxy} = sq2_sb;

    // s never exceeds 2^31, so 5 - 2s + lsb stays positive
    assign n_next = FIVE30P - {sq2_root, 1'b0};

    // stage 7: chi numerator times reciprocal of three
    logic                p7_vld_reg;
    logic [N_W-1:0]      p7_n_reg;
    logic [2*N_W-1:0]    p7_prod_reg;
    logic [Q_W-1:0]      p7_rxx_reg, p7_rxy_reg, p7_ryy_reg;
    logic [PSI_W-1:0]    p7_psi0_reg;
    logic [FLUX_W-1:0]   p7_fx_reg, p7_fy_reg;
    logic                p7_negxy_reg;

    // stage 8: chi with quotient correction and clamp to one
    logic              p8_vld_reg;
    logic [Q_W-1:0]    p8_chi_reg;
    logic [Q_W-1:0]    p8_rxx_reg, p8_rxy_reg, p8_ryy_reg;
    logic [PSI_W-1:0]  p8_psi0_reg;
    logic [FLUX_W-1:0] p8_fx_reg, p8_fy_reg;
    logic              p8_negxy_reg;

    logic [N_W-1:0] q0;
    logic [N_W-1:0] rem3;
    logic [N_W-1:0] chi_raw;
    logic [Q_W-1:0] chi_next;

    assign q0       = N_W'(p7_prod_reg >> RECIP3_SHIFT);
    assign rem3     = p7_n_reg - (q0 + (q0 << 1));
    assign chi_raw  = (rem3 >= N_W'(3)) ? q0 + N_W'(1) : q0;
    assign chi_next = (chi_raw > N_W'(ONE30)) ? ONE30 : chi_raw[Q_W-1:0];

    // stage 9: a = 0.5(1-chi) in q0.31, b = 0.5(3chi-1) in q1.31
    logic              p9_vld_reg;
    logic [Q_W-1:0]    p9_a_reg;
    logic [OUT_W-1:0]  p9_b_reg;
    logic [Q_W-1:0]    p9_rxx_reg, p9_rxy_reg, p9_ryy_reg;
    logic [PSI_W-1:0]  p9_psi0_reg;
    logic [FLUX_W-1:0] p9_fx_reg, p9_fy_reg;
    logic              p9_negxy_reg;

    logic [N_W-1:0] chi3;
    logic [N_W-1:0] b_full;

    assign chi3   = N_W'(p8_chi_reg) + (N_W'(p8_chi_reg) << 1);
    assign b_full = (chi3 > N_W'(ONE30)) ? chi3 - N_W'(ONE30) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p7_vld_reg <= 1'b0;
            p8_vld_reg <= 1'b0;
            p9_vld_reg <= 1'b0;
        end else if (adv) begin
            p7_vld_reg <= sq2_vld;
            p8_vld_reg <= p7_vld_reg;
            p9_vld_reg <= p8_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p7_n_reg     <= n_next;
            p7_prod_reg  <= (2*N_W)'(n_next) * (2*N_W)'(RECIP3);
            p7_rxx_reg   <= q2_rxx;
            p7_rxy_reg   <= q2_rxy;
            p7_ryy_reg   <= q2_ryy;
            p7_psi0_reg  <= q2_psi0;
            p7_fx_reg    <= q2_fx;
            p7_fy_reg    <= q2_fy;
            p7_negxy_reg <= q2_negxy;

            p8_chi_reg   <= chi_next;
            p8_rxx_reg   <= p7_rxx_reg;
            p8_rxy_reg   <= p7_rxy_reg;
            p8_ryy_reg   <= p7_ryy_reg;
            p8_psi0_reg  <= p7_psi0_reg;
            p8_fx_reg    <= p7_fx_reg;
            p8_fy_reg    <= p7_fy_reg;
            p8_negxy_reg <= p7_negxy_reg;

            p9_a_reg     <= ONE30 - p8_chi_reg;
            p9_b_reg     <= b_full[OUT_W-1:0];
            p9_rxx_reg   <= p8_rxx_reg;
            p9_rxy_reg   <= p8_rxy_reg;
            p9_ryy_reg   <= p8_ryy_reg;
            p9_psi0_reg  <= p8_psi0_reg;
            p9_fx_reg    <= p8_fx_reg;
            p9_fy_reg    <= p8_fy_reg;
            p9_negxy_reg <= p8_negxy_reg;
        end
    end

    // stage 10: b * r for each tensor entry
    logic              p10_vld_reg;
    logic [SQ_W-1:0]   p10_bxx_reg, p10_bxy_reg, p10_byy_reg;
    logic [Q_W-1:0]    p10_a_reg;
    logic [PSI_W-1:0]  p10_psi0_reg;
    logic [FLUX_W-1:0] p10_fx_reg, p10_fy_reg;
    logic              p10_negxy_reg;

    // stage 11: coefficient magnitudes and sign of the off-diagonal entry
    logic              p11_vld_reg;
    logic [OUT_W-1:0]  p11_cxx_reg, p11_cxy_reg, p11_cyy_reg;
    logic              p11_cneg_reg;
    logic [PSI_W-1:0]  p11_psi0_reg;
    logic [FLUX_W-1:0] p11_fx_reg, p11_fy_reg;

    logic [SQ_W-1:0]  txx_rnd, txy_rnd, tyy_rnd;
    logic [OUT_W-1:0] txx, txy, tyy;

    assign txx_rnd = p10_bxx_reg + SQ_W'(HALF30);
    assign txy_rnd = p10_bxy_reg + SQ_W'(HALF30);
    assign tyy_rnd = p10_byy_reg + SQ_W'(HALF30);
    assign txx     = txx_rnd[61:30];
    assign txy     = txy_rnd[61:30];
    assign tyy     = tyy_rnd[61:30];

    // stage 12: psi0 times coefficient
    logic              p12_vld_reg;
    logic [SQ_W-1:0]   p12_pxx_reg, p12_pxy_reg, p12_pyy_reg;
    logic              p12_cneg_reg;
    logic [FLUX_W-1:0] p12_fx_reg, p12_fy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p10_vld_reg <= 1'b0;
            p11_vld_reg <= 1'b0;
            p12_vld_reg <= 1'b0;
        end else if (adv) begin
            p10_vld_reg <= p9_vld_reg;
            p11_vld_reg <= p10_vld_reg;
            p12_vld_reg <= p11_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p10_bxx_reg   <= SQ_W'(p9_b_reg) * SQ_W'(p9_rxx_reg);
            p10_bxy_reg   <= SQ_W'(p9_b_reg) * SQ_W'(p9_rxy_reg);
            p10_byy_reg   <= SQ_W'(p9_b_reg) * SQ_W'(p9_ryy_reg);
            p10_a_reg     <= p9_a_reg;
            p10_psi0_reg  <= p9_psi0_reg;
            p10_fx_reg    <= p9_fx_reg;
            p10_fy_reg    <= p9_fy_reg;
            p10_negxy_reg <= p9_negxy_reg;

            p11_cxx_reg   <= OUT_W'(p10_a_reg) + txx;
            p11_cxy_reg   <= txy;
            p11_cyy_reg   <= OUT_W'(p10_a_reg) + tyy;
            p11_cneg_reg  <= p10_negxy_reg && (txy != '0);
            p11_psi0_reg  <= p10_psi0_reg;
            p11_fx_reg    <= p10_fx_reg;
            p11_fy_reg    <= p10_fy_reg;

            p12_pxx_reg   <= SQ_W'(p11_psi0_reg) * SQ_W'(p11_cxx_reg);
            p12_pxy_reg   <= SQ_W'(p11_psi0_reg) * SQ_W'(p11_cxy_reg);
            p12_pyy_reg   <= SQ_W'(p11_psi0_reg) * SQ_W'(p11_cyy_reg);
            p12_cneg_reg  <= p11_cneg_reg;
            p12_fx_reg    <= p11_fx_reg;
            p12_fy_reg    <= p11_fy_reg;
        end
    end

    // stage 13: rounding, saturation, output register
    logic [OUT_W-1:0] out_fx_reg, out_fy_reg;
    logic [OUT_W-1:0] out_xx_reg, out_xy_reg, out_yy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            out_vld_reg <= p12_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_fx_reg <= p12_fx_reg;
            out_fy_reg <= p12_fy_reg;
            out_xx_reg <= scale_sat(p12_pxx_reg, 1'b0);
            out_xy_reg <= scale_sat(p12_pxy_reg, p12_cneg_reg);
            out_yy_reg <= scale_sat(p12_pyy_reg, 1'b0);
        end
    end

    assign m_energy_flux_x = $signed(out_fx_reg);
    assign m_energy_flux_y = $signed(out_fy_reg);
    assign m_pressure_xx   = $signed(out_xx_reg);
    assign m_pressure_xy   = $signed(out_xy_reg);
    assign m_pressure_yy   = $signed(out_yy_reg);

endmodule

// ===== tb/m1_closure_flux_2d_tb.sv =====
// self-checking bench for the m1 closure flux block: directed corner nodes, then random nodes
// depends on m1cf_pkg and the m1_closure_flux_2d rtl
`timescale 1ns / 1ps

module m1_closure_flux_2d_tb
    import m1cf_pkg::*;
();

    typedef struct packed {
        logic [PSI_W-1:0]         psi0;
        logic signed [FLUX_W-1:0] fx;
        logic signed [FLUX_W-1:0] fy;
    } node_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] efx;
        logic signed [OUT_W-1:0] efy;
        logic signed [OUT_W-1:0] pxx;
        logic signed [OUT_W-1:0] pxy;
        logic signed [OUT_W-1:0] pyy;
    } flux_t;

    localparam int LATENCY = 108;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [PSI_W-1:0] s_energy_density = '0;
    logic signed [FLUX_W-1:0] s_flux_x = '0;
    logic signed [FLUX_W-1:0] s_flux_y = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [OUT_W-1:0] m_energy_flux_x, m_energy_flux_y;
    logic signed [OUT_W-1:0] m_pressure_xx, m_pressure_xy, m_pressure_yy;

    node_t pending_nodes[$];
    flux_t expected_fluxes[$];
    int error_count = 0;
    int nodes_sent = 0;
    int fluxes_checked = 0;
    bit busy_phase = 1'b0;   // no idling on either side while set

    always #5 aclk = ~aclk;

    m1_closure_flux_2d u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_energy_density(s_energy_density), .s_flux_x(s_flux_x), .s_flux_y(s_flux_y),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_energy_flux_x(m_energy_flux_x), .m_energy_flux_y(m_energy_flux_y),
        .m_pressure_xx(m_pressure_xx), .m_pressure_xy(m_pressure_xy),
        .m_pressure_yy(m_pressure_yy)
    );

    // bitwise integer square root, floor
    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // psi0 times a signed q0.31 coefficient, rounded and saturated to q8.24
    function automatic logic signed [OUT_W-1:0] scale_psi0(input logic [63:0] psi0,
                                                           input bit neg,
                                                           input logic [63:0] mag);
        logic [63:0] m;
        m = (psi0 * mag + (64'd1 << 30)) >> 31;
        if (!neg) begin
            if (m > 64'h7FFF_FFFF) m = 64'h7FFF_FFFF;
            return m[31:0];
        end
        if (m > 64'h8000_0000) m = 64'h8000_0000;
        return OUT_W'(64'd0 - m);
    endfunction

    // expected flux and pressure tensor for one node
    function automatic flux_t closure_flux(input node_t n);
        logic [63:0] psi0, ax, ay, sq, m, den, f, f2, t, s, chi, a31, b31, one;
        logic [63:0] rxx, rxy, ryy, txx, txy, tyy;
        bit nx, ny;
        flux_t r;
        one = 64'd1 << 30;
        psi0 = n.psi0;
        nx = n.fx[31];
        ny = n.fy[31];
        ax = nx ? (64'd1 << 32) - {32'd0, n.fx} : {32'd0, n.fx};
        ay = ny ? (64'd1 << 32) - {32'd0, n.fy} : {32'd0, n.fy};
        sq = ax * ax + ay * ay;
        m = int_sqrt(sq);
        den = psi0 != 0 ? psi0 : 64'd1;
        f = (m << 30) / den;
        if (f > one) f = one;
        f2 = (f * f + (one >> 1)) >> 30;
        t = (4 * one > 3 * f2) ? 4 * one - 3 * f2 : 64'd0;
        s = int_sqrt(t << 30);
        chi = (5 * one - 2 * s + 1) / 3;
        if (chi > one) chi = one;
        a31 = one - chi;
        b31 = (3 * chi > one) ? 3 * chi - one : 64'd0;
        den = sq != 0 ? sq : 64'd1;
        // ratios are at most one, so 128 bit intermediates keep the divide exact
        rxx = 64'(({64'd0, ax * ax} << 30) / den);
        rxy = 64'(({64'd0, ax * ay} << 30) / den);
        ryy = 64'(({64'd0, ay * ay} << 30) / den);
        txx = (b31 * rxx + (one >> 1)) >> 30;
        txy = (b31 * rxy + (one >> 1)) >> 30;
        tyy = (b31 * ryy + (one >> 1)) >> 30;
        r.efx = n.fx;
        r.efy = n.fy;
        r.pxx = scale_psi0(psi0, 1'b0, a31 + txx);
        r.pxy = scale_psi0(psi0, (nx != ny) && txy != 0, txy);
        r.pyy = scale_psi0(psi0, 1'b0, a31 + tyy);
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        if (error_count <= 20)
            $display("mismatch %s at result %0d: got %h expected %h",
                     field, fluxes_checked, got, want);
    endtask

    task automatic add_node(input logic [PSI_W-1:0] p, input logic [31:0] x,
                            input logic [31:0] y);
        node_t n;
        n.psi0 = p;
        n.fx = x;
        n.fy = y;
        pending_nodes.push_back(n);
    endtask

    // driver: payload and valid hold until the transfer
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_fluxes.push_back(closure_flux({s_energy_density, s_flux_x, s_flux_y}));
                nodes_sent++;
            end
            if (!s_valid || s_ready) begin
                if (pending_nodes.size() != 0 &&
                    (busy_phase || $urandom_range(99) >= 31)) begin
                    node_t n;
                    n = pending_nodes.pop_front();
                    s_valid <= 1'b1;
                    s_energy_density <= n.psi0;
                    s_flux_x <= n.fx;
                    s_flux_y <= n.fy;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result transfer with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_fluxes.size() == 0) begin
                    report_mismatch("unexpected", m_pressure_xx, 0);
                end else begin
                    flux_t e;
                    e = expected_fluxes.pop_front();
                    if (m_energy_flux_x !== e.efx) report_mismatch("flux_x", m_energy_flux_x, e.efx);
                    if (m_energy_flux_y !== e.efy) report_mismatch("flux_y", m_energy_flux_y, e.efy);
                    if (m_pressure_xx !== e.pxx) report_mismatch("pxx", m_pressure_xx, e.pxx);
                    if (m_pressure_xy !== e.pxy) report_mismatch("pxy", m_pressure_xy, e.pxy);
                    if (m_pressure_yy !== e.pyy) report_mismatch("pyy", m_pressure_yy, e.pyy);
                end
                fluxes_checked++;
            end
            m_ready <= busy_phase || ($urandom_range(99) >= 31);
        end
    end

    initial begin
        logic [31:0] x, y;
        logic [PSI_W-1:0] p;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed corners: zero density, zero flux, clamped factor, saturation, signs
        add_node(0, 0, 0);
        add_node(0, 32'h0100_0000, 0);
        add_node(31'h0100_0000, 0, 0);
        add_node(31'h7FFF_FFFF, 0, 0);
        add_node(31'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        add_node(31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_node(31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        add_node(31'h7FFF_FFFF, 32'h8000_0000, 0);
        add_node(31'h0100_0000, 32'h0080_0000, 32'hFF80_0000);
        add_node(31'h0100_0000, 32'hFF00_0000, 0);
        add_node(31'h0100_0000, 0, 32'h0100_0000);
        add_node(31'h0100_0000, 32'h0500_0000, 32'h0300_0000);
        add_node(31'h0200_0000, 32'hFFF0_0000, 32'hFFF0_0000);
        add_node(1, 1, 1);
        add_node(1, 32'hFFFF_FFFF, 0);
        add_node(31'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);

        for (int i = 0; i < 1000; i++) begin
            p = PSI_W'($urandom);
            x = $urandom;
            y = $urandom;
            case ($urandom_range(3))
                0: ;                                     // full range
                1: begin                                 // scaled-down flux, density at least one
                    p = PSI_W'($urandom_range(31'h7FFF_FFFF, 31'h0100_0000));
                    x = $signed(x) >>> $urandom_range(31, 3);
                    y = $signed(y) >>> $urandom_range(31, 3);
                end
                2: begin                                 // near the clamp
                    p = PSI_W'($urandom_range(31'h0FFF_FFFF));
                    x = $signed(x) >>> 3;
                    y = $signed(y) >>> $urandom_range(31, 3);
                end
                default: begin                           // one axis zero
                    if ($urandom_range(1)) x = 0; else y = 0;
                end
            endcase
            add_node(p, x, y);
        end

        // a stretch without idling in the middle of the run
        wait (pending_nodes.size() < 600);
        busy_phase = 1'b1;
        wait (pending_nodes.size() < 400);
        busy_phase = 1'b0;

        wait (pending_nodes.size() == 0 && !s_valid);
        wait (expected_fluxes.size() == 0);
        repeat (LATENCY + 20) @(posedge aclk);

        $display("nodes sent %0d, results checked %0d, mismatches %0d",
                 nodes_sent, fluxes_checked, error_count);
        $display("covered zero density, zero flux, clamped flux factor, saturation, random nodes");
        if (error_count == 0 && expected_fluxes.size() == 0)
            $display("m1_closure_flux_2d_tb passed");
        else
            $display("m1_closure_flux_2d_tb failed");
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("m1_closure_flux_2d_tb failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/m1cf_pkg.sv
rtl/m1cf_isqrt.sv
rtl/m1cf_ratio.sv
rtl/m1_closure_flux_2d.sv
tb/m1_closure_flux_2d_tb.sv
